// File: design/arw_pkg.sv
package arw_pkg;

	localparam int PEERS  = 16;
	localparam int WINDOW = 32;

	localparam int IDX_W = (PEERS > 1) ? $clog2(PEERS) : 1;
	localparam int DST_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SEQ_W = 64;
	localparam int PID_W = 16;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_CHECK  = 2'd1,
		OP_COMMIT = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_UNKNOWN = 3'd1,
		STAT_REPLAY  = 3'd2,
		STAT_PRESENT = 3'd3,
		STAT_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [15:0]      iv_prefix;
		logic [PID_W-1:0] peer_id;
		logic [SEQ_W-1:0] sequence_req;
	} req_item_t;

	typedef struct packed {
		logic       accepted;
		logic [2:0] status;
	} rsp_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_EXEC,
		S_RESULT
	} fsm_state_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic exec;
	} dp_cmd_t;

endpackage

// File: design/anti_replay_window_table_unit.sv
// anti-replay window table: one sliding window per peer, up to PEERS peers.
// request channel (req_valid / req_stall / req) carries opcode, iv_prefix,
// peer_id and sequence_req; a transaction is taken when req_valid is high
// and req_stall is low. opcodes: add peer, check sequence, commit sequence.
// response channel (rsp_valid / rsp_stall / rsp) returns accepted and
// status, exactly one response per request, in order.
// after the request transaction the controller passes through the peer
// lookup state, then the window compare/update state into the result
// register, and then raises rsp_valid. the block handles one request at
// a time, so a new request is taken in the cycle after the response
// leaves. the controller walks load, lookup, execute and result for each
// request.
// while rsp_stall is high the response holds steady and req_stall stays
// high, so no new request is taken until the response is delivered.
// reset empties the table at once (all valid bits clear) and returns the
// controller to idle; no clearing pass is needed.
module anti_replay_window_table_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  arw_pkg::req_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output arw_pkg::rsp_item_t  rsp
);
	import arw_pkg::*;

	dp_cmd_t cmd;

	arw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	arw_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// File: design/arw_datapath.sv
module arw_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  arw_pkg::dp_cmd_t  cmd,
	input  arw_pkg::req_item_t req,
	output arw_pkg::rsp_item_t rsp
);
	import arw_pkg::*;

	// table: valid bits reset, contents written on add/commit only
	logic [PEERS-1:0]  valid_q;
	logic [PID_W-1:0]  peer_q [PEERS];
	logic [SEQ_W-1:0]  top_q [PEERS];
	logic [WINDOW-1:0] bmp_q [PEERS];

	req_item_t         req_q;
	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic              free_any_q;
	logic [IDX_W-1:0]  free_idx_q;
	rsp_item_t         rsp_q;

	// parallel tag compare and lowest free slot
	logic              hit_c;
	logic [IDX_W-1:0]  hit_idx_c;
	logic              free_any_c;
	logic [IDX_W-1:0]  free_idx_c;

	always_comb begin
		hit_c      = 1'b0;
		hit_idx_c  = '0;
		free_any_c = 1'b0;
		free_idx_c = '0;
		for (int i = PEERS - 1; i >= 0; i--) begin
			if (valid_q[i] && (peer_q[i] == req_q.peer_id)) begin
				hit_c     = 1'b1;
				hit_idx_c = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_any_c = 1'b1;
				free_idx_c = IDX_W'(i);
			end
		end
	end

	// window arithmetic on the matched entry
	logic [SEQ_W-1:0]  top_sel;
	logic [WINDOW-1:0] bmp_sel;
	logic              borrow;
	logic [SEQ_W-1:0]  fwd;
	logic [SEQ_W-1:0]  back;
	logic              newer;
	logic              fwd_in;
	logic              back_in;
	logic [WINDOW-1:0] bmp_slid;
	logic [WINDOW-1:0] bmp_mark;

	always_comb begin
		top_sel     = top_q[hit_idx_q];
		bmp_sel     = bmp_q[hit_idx_q];
		{borrow, fwd} = {1'b0, req_q.sequence_req} - {1'b0, top_sel};
		back        = top_sel - req_q.sequence_req;
		newer       = !borrow && (fwd != '0);
		fwd_in      = fwd < SEQ_W'(WINDOW);
		back_in     = back < SEQ_W'(WINDOW);
		bmp_slid    = fwd_in ? ((bmp_sel << fwd[DST_W-1:0]) | WINDOW'(1)) : WINDOW'(1);
		bmp_mark    = bmp_sel | (WINDOW'(1) << back[DST_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.exec && (req_q.opcode == OP_ADD) && !hit_q && free_any_q) begin
			valid_q[free_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.lookup) begin
			hit_q      <= hit_c;
			hit_idx_q  <= hit_idx_c;
			free_any_q <= free_any_c;
			free_idx_q <= free_idx_c;
		end
		if (cmd.exec) begin
			case (req_q.opcode)
				OP_ADD: begin
					if (hit_q) begin
						rsp_q <= '{accepted: 1'b0, status: STAT_PRESENT};
					end else if (free_any_q) begin
						peer_q[free_idx_q] <= req_q.peer_id;
						top_q[free_idx_q]  <= '0;
						bmp_q[free_idx_q]  <= '0;
						rsp_q <= '{accepted: 1'b1, status: STAT_OK};
					end else begin
						rsp_q <= '{accepted: 1'b0, status: STAT_FULL};
					end
				end
				OP_CHECK: begin
					if ((req_q.iv_prefix != '0) || !hit_q) begin
						rsp_q <= '{accepted: 1'b0, status: STAT_UNKNOWN};
					end else if (newer || (back_in && !bmp_sel[back[DST_W-1:0]])) begin
						rsp_q <= '{accepted: 1'b1, status: STAT_OK};
					end else begin
						rsp_q <= '{accepted: 1'b0, status: STAT_REPLAY};
					end
				end
				OP_COMMIT: begin
					if (!hit_q) begin
						rsp_q <= '{accepted: 1'b0, status: STAT_UNKNOWN};
					end else begin
						if (newer) begin
							top_q[hit_idx_q] <= req_q.sequence_req;
							bmp_q[hit_idx_q] <= bmp_slid;
						end else if (back_in) begin
							bmp_q[hit_idx_q] <= bmp_mark;
						end
						rsp_q <= '{accepted: 1'b1, status: STAT_OK};
					end
				end
				default: begin
					rsp_q <= '{accepted: 1'b0, status: STAT_UNKNOWN};
				end
			endcase
		end
	end

	assign rsp = rsp_q;

endmodule

// File: design/arw_ctrl.sv
module arw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output arw_pkg::dp_cmd_t cmd
);
	import arw_pkg::*;

	fsm_state_t state_q;
	fsm_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		req_stall = 1'b1;
		rsp_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_nx = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_nx   = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_nx = S_RESULT;
			end
			S_RESULT: begin
				rsp_valid = 1'b1;
				if (!rsp_stall) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule
